// ===== hw/rtl/hashwh_pkg.sv =====
package hashwh_pkg;

  // Request operation codes.
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [1:0] KIND_EXPIRED  = 2'd2;
  localparam logic [1:0] KIND_IDLE     = 2'd3;

  // A tick stops its walk after this many expiries.
  localparam int MAX_RESULTS = 32;

  localparam int DELAY_W  = 16;
  localparam int HANDLE_W = 8;

  typedef struct packed {
    logic                func;
    logic [DELAY_W-1:0]  delay;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [HANDLE_W-1:0] expired_handle;
    logic                last;
  } rsp_t;

endpackage

// ===== hw/rtl/hashed_timer_wheel_top.sv =====
// Hashed timing wheel with a fixed pool of POOL_ENTRIES timers.
// Request channel (req_valid/req_ready/req): func selects an add of a timer
// (delay, handle) or one tick of time. Response channel (rsp_valid/rsp_ready/
// rsp): kind, expired_handle and last; last marks the final response of a
// request.
// One request is worked on at a time; req_ready is high only while idle.
// An add answers with one response. On a wheel that is not a power of
// two, the delay is split by a two-stage reciprocal multiplier.
// A tick reads the slot head, then walks the slot list one entry per cycle
// through the entry memory, unless a stalled receiver holds it, and ends
// with the final response.
// Expiries come out in walk order; the last expiry is held back one step so
// that it can carry the last flag.
// After reset the slot-head memory is cleared one slot per cycle; req_ready
// stays low meanwhile.
// When the receiver stalls, the response register holds its item and the
// walk waits at the next response it must hand over.
module hashed_timer_wheel_top #(
  parameter int WHEEL_SLOTS  = 64,
  parameter int POOL_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  hashwh_pkg::req_t  req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output hashwh_pkg::rsp_t  rsp
);

  localparam int SLW = $clog2(WHEEL_SLOTS);
  localparam int EW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int RW  = hashwh_pkg::DELAY_W - ($clog2(WHEEL_SLOTS + 1) - 1);
  localparam int HW  = hashwh_pkg::HANDLE_W;
  localparam int CW  = $clog2(POOL_ENTRIES + 1);
  localparam int NW  = $clog2(hashwh_pkg::MAX_RESULTS + 1);
  // Slot word: {valid, head}. Entry word: {next valid, next, rotations, handle}.
  localparam int SWD = 1 + EW;
  localparam int EWD = 1 + EW + RW + HW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_AWR   = 8'b0000_1000,
    S_FULL  = 8'b0001_0000,
    S_THEAD = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_TEND  = 8'b1000_0000
  } state_t;

  state_t state;

  // Memories and their ports.
  logic [SWD-1:0] slot_mem [WHEEL_SLOTS];
  logic [EWD-1:0] ent_mem  [POOL_ENTRIES];

  logic           slot_we, slot_re;
  logic [SLW-1:0] slot_waddr, slot_raddr;
  logic [SWD-1:0] slot_wdata, slot_q;
  logic           ent_we, ent_re;
  logic [EW-1:0]  ent_waddr, ent_raddr;
  logic [EWD-1:0] ent_wdata, ent_q;

  // Control registers.
  logic [SLW-1:0]          cur;
  logic [SLW-1:0]          clr_cnt;
  logic [POOL_ENTRIES-1:0] free_map;
  logic [EW-1:0]           add_idx;
  logic [HW-1:0]           add_hnd;
  logic [SLW-1:0]          add_pos;
  logic [RW-1:0]           add_rot;
  logic [EW-1:0]           idx;
  logic [EW-1:0]           prev_idx;
  logic [RW+HW-1:0]        prev_body;
  logic                    have_prev;
  logic [CW-1:0]           steps;
  logic [NW-1:0]           n;
  logic                    pend_v;
  logic [HW-1:0]           pend_h;

  // Divider and output stage wiring.
  logic             div_start, div_done;
  logic [RW-1:0]    div_quot;
  logic [SLW-1:0]   div_rem;
  logic             push, out_free;
  hashwh_pkg::rsp_t push_data;

  logic            accept;
  logic            found;
  logic [EW-1:0]   free_idx;
  logic [SLW:0]    pos_sum;
  logic [SLW-1:0]  pos_calc;
  logic            slot_v;
  logic [EW-1:0]   slot_head;
  logic            ent_nv;
  logic [EW-1:0]   ent_nx;
  logic [RW-1:0]   ent_rot;
  logic [HW-1:0]   ent_hnd;
  logic            walk_exp, walk_stall, walk_more;
  logic [CW-1:0]   steps_inc;
  logic [NW-1:0]   n_inc;
  logic [SLW-1:0]  cur_inc;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // Lowest free pool entry.
  always_comb begin
    free_idx = '0;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        free_idx = EW'(i);
      end
    end
  end
  assign found = |free_map;

  // Target slot of an add: (delay mod slots + current) mod slots.
  assign pos_sum  = {1'b0, div_rem} + {1'b0, cur};
  assign pos_calc = (pos_sum >= (SLW+1)'(WHEEL_SLOTS)) ?
                    SLW'(pos_sum - (SLW+1)'(WHEEL_SLOTS)) : SLW'(pos_sum);

  assign cur_inc = (cur == SLW'(WHEEL_SLOTS - 1)) ? '0 : cur + 1'b1;

  // Fields of the memory read words.
  assign slot_v    = slot_q[SWD-1];
  assign slot_head = slot_q[EW-1:0];
  assign ent_nv    = ent_q[EWD-1];
  assign ent_nx    = ent_q[EWD-2 -: EW];
  assign ent_rot   = ent_q[HW +: RW];
  assign ent_hnd   = ent_q[HW-1:0];

  // Walk decisions for the entry now on the read port.
  assign walk_exp   = (ent_rot == '0);
  assign walk_stall = walk_exp && pend_v && !out_free;
  assign steps_inc  = steps + 1'b1;
  assign n_inc      = walk_exp ? n + 1'b1 : n;
  assign walk_more  = ent_nv && (steps_inc < CW'(POOL_ENTRIES)) &&
                      (n_inc < NW'(hashwh_pkg::MAX_RESULTS));

  // Memory port control and response pushes.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = cur;
    slot_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = cur;
    ent_we     = 1'b0;
    ent_waddr  = idx;
    ent_wdata  = '0;
    ent_re     = 1'b0;
    ent_raddr  = ent_nx;
    div_start  = 1'b0;
    push       = 1'b0;
    push_data  = '0;
    case (state)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt;
      end
      S_IDLE: begin
        if (accept) begin
          if (req.func == hashwh_pkg::FUNC_TICK) begin
            slot_re = 1'b1;
          end else if (found) begin
            div_start = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          slot_re    = 1'b1;
          slot_raddr = pos_calc;
        end
      end
      S_AWR: begin
        if (out_free) begin
          ent_we         = 1'b1;
          ent_waddr      = add_idx;
          ent_wdata      = {slot_v, slot_head, add_rot, add_hnd};
          slot_we        = 1'b1;
          slot_waddr     = add_pos;
          slot_wdata     = {1'b1, add_idx};
          push           = 1'b1;
          push_data.kind = hashwh_pkg::KIND_ADD_OK;
          push_data.last = 1'b1;
        end
      end
      S_FULL: begin
        if (out_free) begin
          push           = 1'b1;
          push_data.kind = hashwh_pkg::KIND_ADD_FULL;
          push_data.last = 1'b1;
        end
      end
      S_THEAD: begin
        if (slot_v) begin
          ent_re    = 1'b1;
          ent_raddr = slot_head;
        end
      end
      S_WALK: begin
        if (!walk_stall) begin
          if (!walk_exp) begin
            // Entry survives this turn: count down one rotation.
            ent_we    = 1'b1;
            ent_waddr = idx;
            ent_wdata = {ent_nv, ent_nx, ent_rot - 1'b1, ent_hnd};
          end else begin
            // Entry expires: hand over the held expiry and unlink this one.
            if (pend_v) begin
              push                     = 1'b1;
              push_data.kind           = hashwh_pkg::KIND_EXPIRED;
              push_data.expired_handle = pend_h;
            end
            if (have_prev) begin
              ent_we    = 1'b1;
              ent_waddr = prev_idx;
              ent_wdata = {ent_nv, ent_nx, prev_body};
            end else begin
              slot_we    = 1'b1;
              slot_wdata = {ent_nv, ent_nx};
            end
          end
          ent_re = walk_more;
        end
      end
      S_TEND: begin
        if (out_free) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          if (pend_v) begin
            push_data.kind           = hashwh_pkg::KIND_EXPIRED;
            push_data.expired_handle = pend_h;
          end else begin
            push_data.kind = hashwh_pkg::KIND_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      cur      <= '0;
      free_map <= '1;
      pend_v   <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SLW'(WHEEL_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (req.func == hashwh_pkg::FUNC_TICK) begin
              state <= S_THEAD;
            end else if (found) begin
              state <= S_DIV;
            end else begin
              state <= S_FULL;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_AWR;
          end
        end
        S_AWR: begin
          if (out_free) begin
            free_map[add_idx] <= 1'b0;
            state             <= S_IDLE;
          end
        end
        S_FULL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_THEAD: begin
          state <= slot_v ? S_WALK : S_TEND;
        end
        S_WALK: begin
          if (!walk_stall) begin
            if (walk_exp) begin
              free_map[idx] <= 1'b1;
              pend_v        <= 1'b1;
            end
            if (!walk_more) begin
              state <= S_TEND;
            end
          end
        end
        S_TEND: begin
          if (out_free) begin
            pend_v <= 1'b0;
            cur    <= cur_inc;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        add_idx   <= free_idx;
        add_hnd   <= req.handle;
        steps     <= '0;
        n         <= '0;
        have_prev <= 1'b0;
      end
      S_DIV: begin
        add_pos <= pos_calc;
        add_rot <= div_quot;
      end
      S_THEAD: begin
        idx <= slot_head;
      end
      S_WALK: begin
        if (!walk_stall) begin
          steps <= steps_inc;
          n     <= n_inc;
          idx   <= ent_nx;
          if (!walk_exp) begin
            have_prev <= 1'b1;
            prev_idx  <= idx;
            prev_body <= {ent_rot - 1'b1, ent_hnd};
          end else begin
            pend_h <= ent_hnd;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot-head memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_raddr];
    end
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_q <= ent_mem[ent_raddr];
    end
  end

  hashwh_div #(
    .WHEEL_SLOTS(WHEEL_SLOTS),
    .SLW        (SLW),
    .RW         (RW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(req.delay),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  hashwh_out u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .free     (out_free),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

// ===== hw/rtl/hashwh_div.sv =====
module hashwh_div #(
  parameter int WHEEL_SLOTS = 64,
  parameter int SLW         = 6,
  parameter int RW          = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hashwh_pkg::DELAY_W-1:0]  dividend,
  output logic                            done,
  output logic [RW-1:0]                   quot,
  output logic [SLW-1:0]                  rem
);

  localparam int DW = hashwh_pkg::DELAY_W;

  generate
    if ((1 << SLW) == WHEEL_SLOTS) begin : g_pow2
      // Power-of-two wheel: quotient and remainder are plain bit fields.
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          quot <= dividend[DW-1:SLW];
          rem  <= dividend[SLW-1:0];
        end
      end
    end else begin : g_recip
      // Other wheel sizes: multiply by a scaled reciprocal of the slot count,
      // then get the remainder back from the quotient. The scale is chosen so
      // that the quotient is exact for every dividend of the field's width.
      localparam int SH = DW + SLW;
      localparam int MW = DW + 2;
      localparam int PW = DW + MW;
      localparam int QW = PW - SH;
      localparam longint unsigned MULT = ((64'd1 << SH) / WHEEL_SLOTS) + 1;

      logic          stage;
      logic [DW-1:0] dvd;
      logic [PW-1:0] prod;
      logic [QW-1:0] q;
      logic [PW-1:0] back;

      assign q    = prod[PW-1:SH];
      assign back = PW'(q) * PW'(WHEEL_SLOTS);

      // The product is registered first; quotient and remainder are then registered from it.
      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= 1'b0;
          done  <= 1'b0;
        end else begin
          stage <= start;
          done  <= stage;
        end
        if (start) begin
          dvd  <= dividend;
          prod <= PW'(dividend) * PW'(MULT);
        end
        if (stage) begin
          quot <= q[RW-1:0];
          rem  <= SLW'(dvd - back[DW-1:0]);
        end
      end
    end
  endgenerate

endmodule

// ===== hw/rtl/hashwh_out.sv =====
module hashwh_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hashwh_pkg::rsp_t  push_data,
  output logic              free,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output hashwh_pkg::rsp_t  rsp
);

  // The register can take a new result when empty or being drained this cycle.
  assign free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (push) begin
      rsp <= push_data;
    end
  end

endmodule

// ===== hw/rtl/hashwh_chk.sv =====
module hashwh_chk (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input hashwh_pkg::req_t  req,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input hashwh_pkg::rsp_t  rsp
);

  // A stalled response keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Only expiries carry a handle.
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind != hashwh_pkg::KIND_EXPIRED |-> rsp.expired_handle == '0)
    else $error("handle on a response that is not an expiry");

  // Add answers and quiet ticks are single responses.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == hashwh_pkg::KIND_ADD_OK ||
                  rsp.kind == hashwh_pkg::KIND_ADD_FULL ||
                  rsp.kind == hashwh_pkg::KIND_IDLE) |-> rsp.last)
    else $error("single response without last");

  // Requests are refused while the slot memory is being cleared.
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("ready or response right after reset");

  // No new request is taken while a response that is not the last of its request waits to leave.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready && !rsp.last |-> !req_ready)
    else $error("request accepted in the middle of a tick");

endmodule

bind hashed_timer_wheel_top hashwh_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_ready(req_ready),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);

// ===== tb/sv/hashwh_checker.sv =====
`timescale 1ns / 100ps

module hashwh_checker #(
  parameter int WHEEL_SLOTS  = 64,
  parameter int POOL_ENTRIES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  hashwh_pkg::req_t req,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  hashwh_pkg::rsp_t rsp,
  output int               fail_count,
  output int               outstanding,
  output int               expiry_count,
  output int               refused_count
);

  localparam int SLOT_W  = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
  localparam int ENTRY_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  typedef logic [SLOT_W-1:0]              slot_t;
  typedef logic [ENTRY_W-1:0]             entry_t;
  typedef logic [hashwh_pkg::DELAY_W-1:0] delay_t;

  // Shadow copy of the wheel: slot lists, timer pool and the current slot.
  entry_t                          slot_first   [WHEEL_SLOTS];
  logic                            slot_used    [WHEEL_SLOTS];
  entry_t                          link_next    [POOL_ENTRIES];
  logic                            link_used    [POOL_ENTRIES];
  delay_t                          turns_left   [POOL_ENTRIES];
  logic [hashwh_pkg::HANDLE_W-1:0] timer_handle [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0]         free_map;
  slot_t                           now_slot;

  // Responses the block still owes, oldest first.
  hashwh_pkg::rsp_t owed_results[$];

  int errors;
  int expiries;
  int refusals;

  // An add takes the lowest free entry and pushes it onto its slot list.
  task automatic model_add_timer(input hashwh_pkg::req_t r);
    hashwh_pkg::rsp_t item;
    int               pick;
    int               pos;
    pick = -1;
    for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
      if (free_map[i]) pick = i;
    end
    item.expired_handle = '0;
    item.last           = 1'b1;
    if (pick < 0) begin
      item.kind = hashwh_pkg::KIND_ADD_FULL;
      refusals++;
    end else begin
      pos                = (int'(r.delay) + int'(now_slot)) % WHEEL_SLOTS;
      free_map[pick]     = 1'b0;
      link_next[pick]    = slot_first[pos];
      link_used[pick]    = slot_used[pos];
      slot_first[pos]    = entry_t'(pick);
      slot_used[pos]     = 1'b1;
      turns_left[pick]   = delay_t'(r.delay / WHEEL_SLOTS);
      timer_handle[pick] = r.handle;
      item.kind          = hashwh_pkg::KIND_ADD_OK;
    end
    owed_results.push_back(item);
  endtask

  // A tick walks the current slot newest-first, ages or expires each entry,
  // then moves to the next slot. The newest expiry is held back so that the
  // final one can carry the last flag.
  task automatic model_tick();
    hashwh_pkg::rsp_t held;
    logic             have_held;
    logic             have_prev;
    logic             have;
    logic             nv;
    entry_t           prev;
    entry_t           e;
    entry_t           nx;
    int               n;
    int               steps;
    have_held = 1'b0;
    have_prev = 1'b0;
    prev      = '0;
    have      = slot_used[now_slot];
    e         = slot_first[now_slot];
    n         = 0;
    steps     = 0;
    while (have && steps < POOL_ENTRIES && n < hashwh_pkg::MAX_RESULTS) begin
      nv = link_used[e];
      nx = link_next[e];
      steps++;
      if (turns_left[e] != '0) begin
        turns_left[e] = turns_left[e] - 1'b1;
        have_prev     = 1'b1;
        prev          = e;
      end else begin
        if (have_held) owed_results.push_back(held);
        held.kind           = hashwh_pkg::KIND_EXPIRED;
        held.expired_handle = timer_handle[e];
        held.last           = 1'b0;
        have_held           = 1'b1;
        n++;
        expiries++;
        if (have_prev) begin
          link_next[prev] = nx;
          link_used[prev] = nv;
        end else begin
          slot_first[now_slot] = nx;
          slot_used[now_slot]  = nv;
        end
        free_map[e] = 1'b1;
      end
      have = nv;
      e    = nx;
    end
    now_slot = (int'(now_slot) == WHEEL_SLOTS - 1) ? '0 : now_slot + 1'b1;
    if (have_held) begin
      held.last = 1'b1;
      owed_results.push_back(held);
    end else begin
      held.kind           = hashwh_pkg::KIND_IDLE;
      held.expired_handle = '0;
      held.last           = 1'b1;
      owed_results.push_back(held);
    end
  endtask

  // Predict on every accepted request, compare on every accepted response.
  always @(posedge clk) begin
    hashwh_pkg::rsp_t want;
    if (rst) begin
      for (int s = 0; s < WHEEL_SLOTS; s++) slot_used[s] = 1'b0;
      free_map = '1;
      now_slot = '0;
      owed_results.delete();
      errors   = 0;
      expiries = 0;
      refusals = 0;
    end else begin
      if (req_valid && req_ready) begin
        if (req.func == hashwh_pkg::FUNC_TICK) begin
          model_tick();
        end else begin
          model_add_timer(req);
        end
      end
      if (rsp_valid && rsp_ready) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected response, expected none, got kind %0d handle %02h last %0b",
                   $time, rsp.kind, rsp.expired_handle, rsp.last);
        end else begin
          want = owed_results.pop_front();
          if (rsp.kind !== want.kind || rsp.expired_handle !== want.expired_handle ||
              rsp.last !== want.last) begin
            errors++;
            $display("%0t: response mismatch, expected kind %0d handle %02h last %0b",
                     $time, want.kind, want.expired_handle, want.last);
            $display("%0t:                    actual kind %0d handle %02h last %0b",
                     $time, rsp.kind, rsp.expired_handle, rsp.last);
          end
        end
      end
    end
    fail_count    <= errors;
    outstanding   <= owed_results.size();
    expiry_count  <= expiries;
    refused_count <= refusals;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int WHEEL_SLOTS    = 64;
  localparam int POOL_ENTRIES   = 32;
  localparam int PHASE_ITEMS    = 90;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_DRAIN      = 40;

  typedef logic [hashwh_pkg::DELAY_W-1:0]  delay_t;
  typedef logic [hashwh_pkg::HANDLE_W-1:0] handle_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  hashwh_pkg::req_t req       = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  hashwh_pkg::rsp_t rsp;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int adds_sent      = 0;
  int ticks_sent     = 0;
  int quiet_cycles   = 0;

  int fail_count;
  int outstanding;
  int expiry_count;
  int refused_count;

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  hashed_timer_wheel_top #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .POOL_ENTRIES(POOL_ENTRIES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  hashwh_checker #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .POOL_ENTRIES(POOL_ENTRIES)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .expiry_count (expiry_count),
    .refused_count(refused_count)
  );

  // Receiver stalls at random according to the current idling mix.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, stopping", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one request after an optional random gap and hold it until taken.
  // Valid stays high on return so back-to-back requests need no lowering.
  task automatic send_request(input logic func, input delay_t delay,
                              input handle_t handle);
    hashwh_pkg::req_t item;
    item.func   = func;
    item.delay  = delay;
    item.handle = handle;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    if (func == hashwh_pkg::FUNC_ADD) adds_sent++;
    else ticks_sent++;
  endtask

  // Mostly delays within a few turns, now and then far in the future.
  function automatic delay_t random_delay();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return delay_t'($urandom_range(70));
    if (pick < 93) return delay_t'($urandom_range(300));
    if (pick < 98) return delay_t'($urandom_range(4095));
    return delay_t'($urandom_range(65535));
  endfunction

  initial begin
    int add_pct;
    int lead;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 25;
          recv_stall_pct = 45;
        end
        1: begin
          send_idle_pct  = 45;
          recv_stall_pct = 25;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      // Between mixes the sender holds off until the wheel has answered all.
      if (phase > 0) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
      end

      if (phase == 0) begin
        // Tick on an empty slot with junk in the ignored fields.
        send_request(hashwh_pkg::FUNC_TICK, 16'hFFFF, 8'hFF);
        // Zero delay lands in the current slot and expires on the next tick.
        send_request(hashwh_pkg::FUNC_ADD, 16'h0000, 8'h00);
        send_request(hashwh_pkg::FUNC_TICK, 16'h0000, 8'h00);
        // Largest delay: the most rotations the field allows.
        send_request(hashwh_pkg::FUNC_ADD, 16'hFFFF, 8'hFF);
        // Four timers in one slot with mixed rotations; the walk expires two
        // and unlinks from the middle and the tail of the list.
        send_request(hashwh_pkg::FUNC_ADD, 16'd1, 8'hA5);
        send_request(hashwh_pkg::FUNC_ADD, 16'd65, 8'h5A);
        send_request(hashwh_pkg::FUNC_ADD, 16'd1, 8'h11);
        send_request(hashwh_pkg::FUNC_ADD, 16'd129, 8'h22);
        send_request(hashwh_pkg::FUNC_TICK, 16'h8001, 8'h80);
        send_request(hashwh_pkg::FUNC_TICK, 16'h7FFE, 8'h7F);
        // Exactly one turn, and one short of a turn back into the same slot.
        send_request(hashwh_pkg::FUNC_ADD, 16'd64, 8'h44);
        send_request(hashwh_pkg::FUNC_ADD, 16'd63, 8'h33);
        send_request(hashwh_pkg::FUNC_TICK, 16'h5555, 8'hAA);
        send_request(hashwh_pkg::FUNC_ADD, 16'h8000, 8'h01);
        send_request(hashwh_pkg::FUNC_TICK, 16'hAAAA, 8'h55);
      end

      // Overfill the pool so that several adds are refused.
      if (phase == 1) begin
        repeat (POOL_ENTRIES + 2) begin
          send_request(hashwh_pkg::FUNC_ADD, random_delay(), 8'($urandom));
        end
      end

      while (adds_sent + ticks_sent < (phase + 1) * PHASE_ITEMS) begin
        if ($urandom_range(99) < 45) begin
          // Cluster of timers on one slot a few ticks ahead, then tick past it.
          lead = $urandom_range(6);
          repeat ($urandom_range(2, 5)) begin
            send_request(hashwh_pkg::FUNC_ADD,
                         delay_t'(lead + WHEEL_SLOTS * $urandom_range(2)),
                         8'($urandom));
          end
          repeat (lead + 1 + $urandom_range(2)) begin
            send_request(hashwh_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
          end
        end else begin
          // Loose mix of adds and ticks.
          add_pct = 20 + 25 * $urandom_range(2);
          repeat ($urandom_range(10, 30)) begin
            if ($urandom_range(99) < add_pct) begin
              send_request(hashwh_pkg::FUNC_ADD, random_delay(), 8'($urandom));
            end else begin
              send_request(hashwh_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
            end
          end
        end
      end
    end

    // Drain everything still owed, then watch for stray responses.
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (END_DRAIN) @(posedge clk);

    $display("Sent %0d adds and %0d ticks under three sender/receiver idling mixes.",
             adds_sent, ticks_sent);
    $display("Predicted %0d timer expiries and %0d adds refused on a full pool.",
             expiry_count, refused_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hashwh_pkg.sv
hw/rtl/hashwh_div.sv
hw/rtl/hashwh_out.sv
hw/rtl/hashed_timer_wheel_top.sv
hw/rtl/hashwh_chk.sv
tb/sv/hashwh_checker.sv
tb/sv/tb_top.sv
